[design/dq_pkg.sv]
// shared types and codes for the double-ended queue
package dq_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int MODE_WIDTH   = 3;
   localparam int COUNT_WIDTH  = 5;
   localparam int STATUS_WIDTH = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_QUERY      = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POP_EMPTY  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSH_FULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

[design/double_ended_queue_core.sv]
// Bounded double-ended queue held as a ring buffer in a single ram. Each request beat (push
// front, push back, pop front, pop back or query) returns one response beat with the front
// and back entries after the operation, empty/full flags, the entry count and a status. The
// front and back entries are cached in registers, so pushes, queries, rejected operations and
// pops that leave at most one entry need no ram read; a pop that leaves two or more entries
// stalls new requests while the new end entry is fetched through the ram's registered read
// port. A response beat is held until taken; the next request is taken in the same cycle
// that the pending response drains. No initialization pass after reset.
module double_ended_queue_core
   import dq_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MODE_WIDTH-1:0]   req_mode,
   input  logic [DATA_WIDTH-1:0]   req_entry_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DATA_WIDTH-1:0]   rsp_front_value,
   output logic [DATA_WIDTH-1:0]   rsp_back_value,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full,
   output logic [COUNT_WIDTH-1:0]  rsp_entry_count,
   output logic [STATUS_WIDTH-1:0] rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ENTRY_WIDTH-1:0]  fval_ff, fval_in;
   logic [ENTRY_WIDTH-1:0]  bval_ff, bval_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic                    pend_front_ff, pend_front_in;

   logic                    accept;
   logic                    out_free;
   logic                    is_empty;
   logic                    is_full;
   logic [ENTRY_WIDTH-1:0]  push_entry;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [ENTRY_WIDTH-1:0]  rd_data;

   function automatic logic [IDX_W-1:0] wrap_slot(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] slot_dec(logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] slot_inc(logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign push_entry = ENTRY_WIDTH'(req_entry_value);

   // response beat is shown straight from the state registers; they only change on accept or on the read fetch
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      front_in      = front_ff;
      count_in      = count_ff;
      fval_in       = fval_ff;
      bval_in       = bval_ff;
      status_in     = status_ff;
      pend_front_in = pend_front_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_DONE;
               unique case (req_mode)
                  MODE_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STATUS_PUSH_FULL;
                     end else begin
                        front_in = slot_dec(front_ff);
                        wr_en    = 1'b1;
                        wr_addr  = slot_dec(front_ff);
                        fval_in  = push_entry;
                        if (is_empty) begin
                           bval_in = push_entry;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_PUSH_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = wrap_slot(front_ff, count_ff);
                        bval_in = push_entry;
                        if (is_empty) begin
                           fval_in = push_entry;
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = STATUS_POP_EMPTY;
                     end else begin
                        front_in = slot_inc(front_ff);
                        count_in = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(2)) begin
                           fval_in = bval_ff;
                        end else if (count_ff > CNT_W'(2)) begin
                           // new front lives in the ram, fetch it before responding
                           rd_en         = 1'b1;
                           rd_addr       = slot_inc(front_ff);
                           pend_front_in = 1'b1;
                           state_in      = ST_READ;
                           rsp_valid_in  = 1'b0;
                        end
                     end
                  end
                  MODE_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_POP_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(2)) begin
                           bval_in = fval_ff;
                        end else if (count_ff > CNT_W'(2)) begin
                           rd_en         = 1'b1;
                           rd_addr       = wrap_slot(front_ff, count_ff - CNT_W'(2));
                           pend_front_in = 1'b0;
                           state_in      = ST_READ;
                           rsp_valid_in  = 1'b0;
                        end
                     end
                  end
                  default: begin
                     // query and unused codes leave the queue as is
                  end
               endcase
            end
         end
         ST_READ: begin
            if (pend_front_ff) begin
               fval_in = rd_data;
            end else begin
               bval_in = rd_data;
            end
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         front_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      fval_ff       <= fval_in;
      bval_ff       <= bval_in;
      status_ff     <= status_in;
      pend_front_ff <= pend_front_in;
   end

   dq_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = is_empty ? '0 : DATA_WIDTH'(fval_ff);
   assign rsp_back_value  = is_empty ? '0 : DATA_WIDTH'(bval_ff);
   assign rsp_is_empty    = is_empty;
   assign rsp_is_full     = is_full;
   assign rsp_entry_count = COUNT_WIDTH'(count_ff);
   assign rsp_status      = status_ff;

endmodule

[design/dq_ram.sv]
// generic single-write, single-read ram with registered read data
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/double_ended_queue_core_tb.sv]
// testbench for the double-ended queue core: directed and random traffic against a predictor
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
   import dq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int REPORT_LIMIT  = 10;

   // modes outside the defined set behave as a query
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_A = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_B = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_C = 3'd7;

   typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} traffic_bias_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]   front_value;
      logic [DATA_WIDTH-1:0]   back_value;
      logic                    is_empty;
      logic                    is_full;
      logic [COUNT_WIDTH-1:0]  entry_count;
      logic [STATUS_WIDTH-1:0] status;
   } deque_view_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MODE_WIDTH-1:0]   req_mode = MODE_QUERY;
   logic [DATA_WIDTH-1:0]   req_entry_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [DATA_WIDTH-1:0]   rsp_front_value;
   logic [DATA_WIDTH-1:0]   rsp_back_value;
   logic                    rsp_is_empty;
   logic                    rsp_is_full;
   logic [COUNT_WIDTH-1:0]  rsp_entry_count;
   logic [STATUS_WIDTH-1:0] rsp_status;

   // shadow copy of the ring
   logic [DATA_WIDTH-1:0]   shadow_slots [QUEUE_DEPTH];
   logic [3:0]              shadow_head = '0;
   logic [COUNT_WIDTH-1:0]  shadow_count = '0;

   deque_view_type          expected_views [$];
   int unsigned             send_idle_pct = 0;
   int unsigned             recv_idle_pct = 0;
   int unsigned             error_count = 0;
   int unsigned             cycle_count = 0;

   double_ended_queue_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // applies one operation to the shadow ring and returns the view after it
   function automatic deque_view_type apply_deque_op(input logic [MODE_WIDTH-1:0] mode,
                                                     input logic [DATA_WIDTH-1:0] value);
      deque_view_type view;
      view.status = STATUS_DONE;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_count == QUEUE_DEPTH) begin
               view.status = STATUS_PUSH_FULL;
            end else if (mode == MODE_PUSH_FRONT) begin
               shadow_head = shadow_head - 4'd1;
               shadow_slots[shadow_head] = value;
               shadow_count = shadow_count + 1'b1;
            end else begin
               shadow_slots[4'(shadow_head + shadow_count[3:0])] = value;
               shadow_count = shadow_count + 1'b1;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               view.status = STATUS_POP_EMPTY;
            end else begin
               if (mode == MODE_POP_FRONT) shadow_head = shadow_head + 4'd1;
               shadow_count = shadow_count - 1'b1;
            end
         end
         default: ;
      endcase
      if (shadow_count == 0) begin
         view.front_value = '0;
         view.back_value  = '0;
      end else begin
         view.front_value = shadow_slots[shadow_head];
         // a full ring wraps the low count bits to zero, which still lands one behind head
         view.back_value  = shadow_slots[4'(shadow_head + shadow_count[3:0] - 4'd1)];
      end
      view.is_empty    = (shadow_count == 0);
      view.is_full     = (shadow_count == QUEUE_DEPTH);
      view.entry_count = shadow_count;
      return view;
   endfunction

   task automatic send_beat(input logic [MODE_WIDTH-1:0] mode,
                            input logic [DATA_WIDTH-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_value <= value;
      do @(posedge clock); while (req_stall);
      expected_views.push_back(apply_deque_op(mode, value));
   endtask

   task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] want,
                              input logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response beat: count %0d status %0d",
                        rsp_entry_count, rsp_status);
         end else begin
            want = expected_views.pop_front();
            check_field("front_value", want.front_value, rsp_front_value);
            check_field("back_value", want.back_value, rsp_back_value);
            check_field("is_empty", DATA_WIDTH'(want.is_empty), DATA_WIDTH'(rsp_is_empty));
            check_field("is_full", DATA_WIDTH'(want.is_full), DATA_WIDTH'(rsp_is_full));
            check_field("entry_count", DATA_WIDTH'(want.entry_count),
                        DATA_WIDTH'(rsp_entry_count));
            check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(rsp_status));
         end
      end
   end

   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_queue();
      send_beat(MODE_QUERY, 32'hFFFF_FFFF);
      send_beat(MODE_POP_FRONT, 32'hFFFF_FFFF);
      send_beat(MODE_POP_BACK, '0);
   endtask

   task automatic test_push_pop_ends();
      send_beat(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
      send_beat(MODE_PUSH_BACK, 32'h0000_0000);
      send_beat(MODE_PUSH_FRONT, 32'hA5A5_A5A5);
      send_beat(MODE_PUSH_BACK, 32'h5A5A_5A5A);
      send_beat(MODE_QUERY, 32'h1234_5678);
      send_beat(MODE_POP_FRONT, 32'hDEAD_BEEF);
      send_beat(MODE_POP_BACK, 32'hDEAD_BEEF);
      send_beat(MODE_POP_FRONT, '0);
      send_beat(MODE_POP_BACK, '0);
      send_beat(MODE_POP_BACK, '0);
   endtask

   task automatic test_unused_modes();
      send_beat(MODE_PUSH_BACK, 32'h8000_0001);
      send_beat(MODE_SPARE_A, 32'hFFFF_FFFF);
      send_beat(MODE_SPARE_B, 32'h7FFF_FFFE);
      send_beat(MODE_SPARE_C, '0);
      send_beat(MODE_POP_FRONT, '0);
   endtask

   // random traffic in bursts that lean toward filling, draining or neither
   task automatic test_random_traffic(input int beats);
      traffic_bias_type      bias;
      int unsigned           push_pct;
      int unsigned           pop_pct;
      int unsigned           roll;
      logic [MODE_WIDTH-1:0] mode;
      bias = BIAS_MIXED;
      for (int i = 0; i < beats; i++) begin
         if (i % 40 == 0) bias = traffic_bias_type'($urandom_range(BIAS_MIXED));
         case (bias)
            BIAS_FILL:  begin push_pct = 75; pop_pct = 15; end
            BIAS_DRAIN: begin push_pct = 15; pop_pct = 75; end
            default:    begin push_pct = 45; pop_pct = 45; end
         endcase
         roll = $urandom_range(99);
         if (roll < push_pct)
            mode = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else if (roll < push_pct + pop_pct)
            mode = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
         else
            mode = MODE_WIDTH'($urandom_range(MODE_QUERY, MODE_SPARE_C));
         send_beat(mode, pick_value());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 56;
      test_empty_queue();
      test_push_pop_ends();
      test_unused_modes();
      test_random_traffic(520);

      send_idle_pct = 56;
      recv_idle_pct = 26;
      test_random_traffic(520);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(540);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
